// ===== rtl/core/ostp_pkg.sv =====
// Package for the one-shot timer pool: sizes, codes and the slot entry type.
package ostp_pkg;

	// Pool depth and derived widths.
	localparam int TIMER_SLOTS = 16;
	localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int ID_W        = 7;
	localparam int WORD_W      = 32;

	// Input item kinds.
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_ACCEPTED = 2'd0,
		KIND_REJECTED = 2'd1,
		KIND_EXPIRED  = 2'd2
	} ostp_kind_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_TICK  = 2'd1,
		ST_FLUSH = 2'd2
	} ostp_state_t;

	// Contents of one timer slot.
	typedef struct packed {
		logic              busy;
		logic              pend;
		logic [WORD_W-1:0] remaining;
		logic [WORD_W-1:0] handler;
		logic [WORD_W-1:0] argument;
	} ostp_entry_t;

	// Per-cell control from the controller.
	typedef struct packed {
		logic shift;
		logic load;
		logic del;
	} ostp_cell_ctrl_t;

endpackage

// ===== rtl/core/ostp_cell.sv =====
// One timer slot of the ring: holds an entry, loads it, marks it, or shifts it on.
module ostp_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ostp_pkg::ostp_cell_ctrl_t ctrl,
	input  ostp_pkg::ostp_entry_t    shift_in,
	input  ostp_pkg::ostp_entry_t    load_data,
	output ostp_pkg::ostp_entry_t    entry
);
	import ostp_pkg::*;

	logic              busy_q;
	logic              pend_q;
	logic [WORD_W-1:0] remaining_q;
	logic [WORD_W-1:0] handler_q;
	logic [WORD_W-1:0] argument_q;

	// Status bits are cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= 1'b0;
		end else if (ctrl.shift) begin
			busy_q <= shift_in.busy;
			pend_q <= shift_in.pend;
		end else if (ctrl.load) begin
			busy_q <= 1'b1;
			pend_q <= 1'b0;
		end else if (ctrl.del && busy_q) begin
			pend_q <= 1'b1;
		end
	end

	// Payload words need no reset; they are only read while the slot is busy.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			remaining_q <= shift_in.remaining;
			handler_q   <= shift_in.handler;
			argument_q  <= shift_in.argument;
		end else if (ctrl.load) begin
			remaining_q <= load_data.remaining;
			handler_q   <= load_data.handler;
			argument_q  <= load_data.argument;
		end
	end

	assign entry = '{busy: busy_q, pend: pend_q, remaining: remaining_q,
		handler: handler_q, argument: argument_q};

endmodule

// ===== rtl/core/one_shot_timer_pool.sv =====
// Top level of the one-shot timer pool: controller, head unit and ring of slot cells.
// An add or a delete is taken while idle with the output free; an add's beat is in the output register next cycle.
// A tick rotates the ring of TIMER_SLOTS cells once, one slot through the head unit per cycle while the
// output register is free, then passes through a flush state before the next item is taken.
// Expired beats wait in a holding register until the next expiry or the flush, so the final one carries last.
// Reset (arst_n low) frees every slot and empties the output; no clearing pass is needed.
module one_shot_timer_pool (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [ostp_pkg::WORD_W-1:0] duration,
	input  logic [ostp_pkg::WORD_W-1:0] elapsed,
	input  logic [ostp_pkg::WORD_W-1:0] handler_tag,
	input  logic [ostp_pkg::WORD_W-1:0] argument,
	input  logic [ostp_pkg::ID_W-1:0]   target_id,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [ostp_pkg::ID_W-1:0]   timer_id,
	output logic [ostp_pkg::WORD_W-1:0] expired_handler,
	output logic [ostp_pkg::WORD_W-1:0] expired_argument,
	output logic                        last
);
	import ostp_pkg::*;

	ostp_state_t       state_q, state_d;
	logic [SLOT_W-1:0] cnt_q;
	logic [WORD_W-1:0] elapsed_q;

	ostp_entry_t       cell_q    [TIMER_SLOTS];
	ostp_cell_ctrl_t   cell_ctrl [TIMER_SLOTS];
	logic [TIMER_SLOTS-1:0] busy_vec;
	logic [TIMER_SLOTS-1:0] pend_vec;

	// Output register.
	logic              out_valid_q;
	ostp_kind_t        kind_q;
	logic [ID_W-1:0]   timer_id_q;
	logic [WORD_W-1:0] handler_q;
	logic [WORD_W-1:0] argument_q;
	logic              last_q;

	// Holding register for the latest expiry of the running tick.
	logic              hold_v_q;
	logic [ID_W-1:0]   hold_id_q;
	logic [WORD_W-1:0] hold_handler_q;
	logic [WORD_W-1:0] hold_arg_q;

	logic              out_free;
	logic              in_beat;
	logic              step;
	logic              flush_push;

	// Controller outputs.
	logic              do_add;
	logic              do_del;
	logic              add_ok;
	logic              emit_add;
	logic              start_tick;

	logic              full;
	logic [SLOT_W-1:0] free_slot;
	logic [SLOT_W-1:0] del_slot;
	logic              del_valid;
	ostp_entry_t       new_entry;

	// Head unit signals.
	ostp_entry_t       head;
	ostp_entry_t       head_next;
	logic [WORD_W-1:0] rem_next;
	logic              head_live;
	logic              expire;
	logic [ID_W-1:0]   head_id;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_beat  = in_valid && in_ready;

	// Status vectors gathered from the cells.
	always_comb begin
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			busy_vec[i] = cell_q[i].busy;
			pend_vec[i] = cell_q[i].pend;
		end
	end

	// Lowest free slot.
	always_comb begin
		free_slot = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!busy_vec[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end
	assign full = &busy_vec;

	// Delete target decode: zero or an id above the pool matches nothing.
	assign del_valid = (target_id != '0) && (target_id <= ID_W'(TIMER_SLOTS));
	assign del_slot  = SLOT_W'(target_id - ID_W'(1));

	assign new_entry = '{busy: 1'b1, pend: 1'b0, remaining: duration,
		handler: handler_tag, argument: argument};

	// Head unit: saturating countdown and expiry of the slot at cell zero.
	assign head      = cell_q[0];
	assign rem_next  = (head.remaining > elapsed_q) ? (head.remaining - elapsed_q) : '0;
	assign head_live = head.busy && !head.pend;
	assign expire    = head_live && (rem_next == '0);
	assign head_id   = ID_W'(cnt_q) + ID_W'(1);
	assign head_next = '{busy: head_live && !expire, pend: 1'b0, remaining: rem_next,
		handler: head.handler, argument: head.argument};

	// Next state and controller outputs.
	always_comb begin
		state_d    = state_q;
		do_add     = 1'b0;
		do_del     = 1'b0;
		add_ok     = 1'b0;
		emit_add   = 1'b0;
		start_tick = 1'b0;
		step       = 1'b0;
		flush_push = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					case (mode)
						MODE_ADD: begin
							emit_add = 1'b1;
							add_ok   = (duration != '0) && (handler_tag != '0) && !full;
							do_add   = add_ok;
						end
						MODE_DELETE: begin
							do_del = del_valid;
						end
						MODE_TICK: begin
							start_tick = 1'b1;
							state_d    = ST_TICK;
						end
						default: begin
						end
					endcase
				end
			end
			ST_TICK: begin
				if (out_free) begin
					step = 1'b1;
					if (cnt_q == SLOT_W'(TIMER_SLOTS - 1)) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!hold_v_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush_push = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Cell controls: the ring shifts towards cell zero on each tick step.
	always_comb begin
		for (int i = 0; i < TIMER_SLOTS; i++) begin
			cell_ctrl[i].shift = step;
			cell_ctrl[i].load  = do_add && (free_slot == SLOT_W'(i));
			cell_ctrl[i].del   = do_del && (del_slot == SLOT_W'(i));
		end
	end

	// Ring of slot cells; the head unit feeds the last one.
	for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
		ostp_entry_t shift_src;
		if (g == TIMER_SLOTS - 1) begin : g_tail
			assign shift_src = head_next;
		end else begin : g_mid
			assign shift_src = cell_q[g + 1];
		end
		ostp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (cell_ctrl[g]),
			.shift_in  (shift_src),
			.load_data (new_entry),
			.entry     (cell_q[g])
		);
	end

	// State, step counter and latched elapsed amount.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (step) begin
				cnt_q <= (cnt_q == SLOT_W'(TIMER_SLOTS - 1)) ? '0 : (cnt_q + SLOT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_tick) begin
			elapsed_q <= elapsed;
		end
	end

	// Holding register valid flag: it empties only when its beat moves to the output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
		end else if (step && expire) begin
			hold_v_q <= 1'b1;
		end else if (flush_push) begin
			hold_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && expire) begin
			hold_id_q      <= head_id;
			hold_handler_q <= head.handler;
			hold_arg_q     <= head.argument;
		end
	end

	// Output register valid flag: a new beat enters only when the register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_add || flush_push || (step && expire && hold_v_q)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (emit_add) begin
			kind_q     <= add_ok ? KIND_ACCEPTED : KIND_REJECTED;
			timer_id_q <= add_ok ? (ID_W'(free_slot) + ID_W'(1)) : '0;
			handler_q  <= '0;
			argument_q <= '0;
			last_q     <= 1'b1;
		end else if (flush_push || (step && expire && hold_v_q)) begin
			kind_q     <= KIND_EXPIRED;
			timer_id_q <= hold_id_q;
			handler_q  <= hold_handler_q;
			argument_q <= hold_arg_q;
			last_q     <= flush_push;
		end
	end

	assign out_valid        = out_valid_q;
	assign kind             = kind_q;
	assign timer_id         = timer_id_q;
	assign expired_handler  = handler_q;
	assign expired_argument = argument_q;
	assign last             = last_q;

	// The holding register is empty whenever the controller is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !hold_v_q)
		else $error("holding register still full while idle");

	// The ring is back in its home position whenever the controller is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("slot ring not at home position while idle");

	// A slot pending removal is always busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_vec & ~busy_vec) == '0)
		else $error("pending removal on a free slot");

	// Add results are always the final beat of their item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != KIND_EXPIRED) |-> last_q)
		else $error("add result without last");

endmodule
